// File: hw/rtl/binary_dilation_erosion_unit_defines.svh
// ----------------------------------------------------------------------------
// Binary dilation / erosion unit: assertion macros
// Shared property wrappers for the concurrent checks of the unit.
// ----------------------------------------------------------------------------
`ifndef BINARY_DILATION_EROSION_UNIT_DEFINES_SVH
`define BINARY_DILATION_EROSION_UNIT_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define BDE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("binary_dilation_erosion_unit: check failed");

// Next-cycle implication, switched off while reset is high.
`define BDE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("binary_dilation_erosion_unit: check failed");

// Check on the cycle after reset, live during reset.
`define BDE_ASSERT_RESET(label, clk, rst, cons) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("binary_dilation_erosion_unit: reset check failed");

`endif

// File: hw/rtl/bde_pkg.sv
// ----------------------------------------------------------------------------
// Binary dilation / erosion package
// Sizes, register indexes and shared types of the unit.
// ----------------------------------------------------------------------------
package bde_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_ROWS    = 1024;
  localparam int MAX_ELEMENT = 8;
  localparam int GRID        = 8;
  localparam int WIN_BITS    = GRID * GRID;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = 10;
  localparam int SIZE_W      = 11;
  localparam int ELEM_W      = 4;
  localparam int LINE_BITS   = MAX_ELEMENT - 1;
  localparam int INDEX_W     = 3;

  localparam logic [WIN_BITS-1:0] COL0_BITS = 64'h0101_0101_0101_0101;

  typedef enum logic [INDEX_W-1:0] {
    REG_MODE           = 3'd0,
    REG_ELEMENT_MASK   = 3'd1,
    REG_ELEMENT_WIDTH  = 3'd2,
    REG_ELEMENT_HEIGHT = 3'd3,
    REG_IMAGE_WIDTH    = 3'd4,
    REG_IMAGE_HEIGHT   = 3'd5
  } reg_index_t;

  localparam logic MODE_DILATE = 1'b0;
  localparam logic MODE_ERODE  = 1'b1;

  // Effective configuration: sizes clamped, masks trimmed to the element.
  typedef struct packed {
    logic                erode;
    logic [WIN_BITS-1:0] dil_mask;
    logic [WIN_BITS-1:0] ero_mask;
    logic [SIZE_W-1:0]   iw;
    logic [SIZE_W-1:0]   ih;
    logic [ELEM_W-1:0]   ew;
    logic [ELEM_W-1:0]   eh;
  } cfg_t;

  // Window stage handed to the result stage.
  typedef struct packed {
    logic                valid;
    logic [WIN_BITS-1:0] window;
    logic [COL_W-1:0]    x;
    logic [ROW_W-1:0]    y;
  } win_stage_t;

endpackage

// File: hw/rtl/bde_pixel_if.sv
// ----------------------------------------------------------------------------
// Pixel input channel
// Valid/ready channel carrying one binary pixel and a frame start flag.
// ----------------------------------------------------------------------------
interface bde_pixel_if;
  logic valid;
  logic ready;
  logic pixel;
  logic frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

// File: hw/rtl/bde_result_if.sv
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying one output pixel and its position.
// ----------------------------------------------------------------------------
interface bde_result_if;
  import bde_pkg::*;
  logic             valid;
  logic             ready;
  logic             out_pixel;
  logic [COL_W-1:0] out_column;
  logic [ROW_W-1:0] out_row;

  modport source (output valid, output out_pixel, output out_column, output out_row,
                  input ready);
  modport sink   (input valid, input out_pixel, input out_column, input out_row,
                  output ready);
endinterface

// File: hw/rtl/bde_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and 64-bit write data.
// ----------------------------------------------------------------------------
interface bde_cfg_if;
  import bde_pkg::*;
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] index;
  logic [63:0]        data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/bde_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
module bde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/bde_config.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the written registers and derives the clamped, trimmed view of them.
// ----------------------------------------------------------------------------
module bde_config import bde_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  logic [INDEX_W-1:0] wr_index,
  input  logic [63:0]        wr_data,
  output cfg_t               cfg
);

  logic                mode;
  logic [WIN_BITS-1:0] element_mask;
  logic [ELEM_W-1:0]   element_width;
  logic [ELEM_W-1:0]   element_height;
  logic [SIZE_W-1:0]   image_width;
  logic [SIZE_W-1:0]   image_height;
  cfg_t                cfg_next;

  assign wr_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_DILATE;
      element_mask   <= WIN_BITS'(1);
      element_width  <= ELEM_W'(1);
      element_height <= ELEM_W'(1);
      image_width    <= SIZE_W'(MAX_WIDTH);
      image_height   <= SIZE_W'(MAX_ROWS);
    end else if (wr_valid) begin
      case (reg_index_t'(wr_index))
        REG_MODE:           mode           <= wr_data[0];
        REG_ELEMENT_MASK:   element_mask   <= wr_data;
        REG_ELEMENT_WIDTH:  element_width  <= wr_data[ELEM_W-1:0];
        REG_ELEMENT_HEIGHT: element_height <= wr_data[ELEM_W-1:0];
        REG_IMAGE_WIDTH:    image_width    <= wr_data[SIZE_W-1:0];
        REG_IMAGE_HEIGHT:   image_height   <= wr_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [ELEM_W-1:0] r_off;
    logic [ELEM_W-1:0] c_off;
    cfg_next       = '0;
    cfg_next.erode = mode;
    cfg_next.iw    = (image_width == '0) ? SIZE_W'(1) :
                     (image_width > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : image_width;
    cfg_next.ih    = (image_height == '0) ? SIZE_W'(1) :
                     (image_height > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : image_height;
    cfg_next.ew    = (element_width == '0) ? ELEM_W'(1) :
                     (element_width > ELEM_W'(MAX_ELEMENT)) ? ELEM_W'(MAX_ELEMENT) :
                     element_width;
    cfg_next.eh    = (element_height == '0) ? ELEM_W'(1) :
                     (element_height > ELEM_W'(MAX_ELEMENT)) ? ELEM_W'(MAX_ELEMENT) :
                     element_height;
    for (int a = 0; a < GRID; a++) begin
      for (int b = 0; b < GRID; b++) begin
        // dilation uses the mask as is, trimmed to the element size
        cfg_next.dil_mask[a*GRID+b] = element_mask[a*GRID+b] &&
                                      (ELEM_W'(a) < cfg_next.eh) &&
                                      (ELEM_W'(b) < cfg_next.ew);
        // erosion looks back from the newest pixel: mirror the element
        r_off = cfg_next.eh - ELEM_W'(a + 1);
        c_off = cfg_next.ew - ELEM_W'(b + 1);
        cfg_next.ero_mask[a*GRID+b] = (ELEM_W'(a) < cfg_next.eh) &&
                                      (ELEM_W'(b) < cfg_next.ew) &&
                                      element_mask[{r_off[2:0], c_off[2:0]}];
      end
    end
  end

  // The view follows a write at once, so a pixel may arrive in the next cycle.
  assign cfg = cfg_next;

endmodule

// File: hw/rtl/bde_line_window.sv
// ----------------------------------------------------------------------------
// Line store and window
// Tracks the raster position, reads the pixels above from the line store and
// shifts the new column into the 8 by 8 window.
// ----------------------------------------------------------------------------
module bde_line_window import bde_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic       in_valid,
  input  logic       pixel,
  input  logic       frame_start,
  input  cfg_t       cfg,
  output win_stage_t stage
);

  logic [COL_W-1:0]     column_count;
  logic [ROW_W-1:0]     row_count;
  logic [COL_W-1:0]     column_count_next;
  logic [ROW_W-1:0]     row_count_next;
  logic [SIZE_W-1:0]    cx;
  logic [SIZE_W-1:0]    cy;
  logic [SIZE_W-1:0]    col_inc;
  logic [SIZE_W-1:0]    row_inc;
  logic [COL_W-1:0]     x;
  logic [ROW_W-1:0]     y;
  logic                 accept;

  logic                 s1_valid;
  logic                 s1_pixel;
  logic [COL_W-1:0]     s1_x;
  logic [ROW_W-1:0]     s1_y;
  logic                 s1_fwd;
  logic [LINE_BITS-1:0] s1_fwd_data;
  logic [LINE_BITS-1:0] rdata;
  logic [LINE_BITS-1:0] above;
  logic [MAX_ELEMENT-1:0] col_bits;
  logic [WIN_BITS-1:0]  spread;
  logic [WIN_BITS-1:0]  window_next;

  assign accept = in_valid && advance;

  // Position of this pixel, with frame start and wrap applied.
  always_comb begin
    cx = frame_start ? '0 : SIZE_W'(column_count);
    cy = frame_start ? '0 : SIZE_W'(row_count);
    if (cx >= cfg.iw) begin
      cx = '0;
      cy = cy + SIZE_W'(1);
    end
    if (cy >= cfg.ih) begin
      cy = '0;
    end
    x       = cx[COL_W-1:0];
    y       = cy[ROW_W-1:0];
    col_inc = SIZE_W'(x) + SIZE_W'(1);
    row_inc = SIZE_W'(y) + SIZE_W'(1);
    if (col_inc >= cfg.iw) begin
      column_count_next = '0;
      row_count_next    = (row_inc >= cfg.ih) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      column_count_next = col_inc[COL_W-1:0];
      row_count_next    = y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  bde_ram #(
    .WIDTH (LINE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_valid && advance),
    .waddr (s1_x),
    .wdata (col_bits[LINE_BITS-1:0]),
    .re    (accept),
    .raddr (x),
    .rdata (rdata)
  );

  // A read at the address written in the same cycle sees old data: forward.
  assign above    = s1_fwd ? s1_fwd_data : rdata;
  assign col_bits = {above, s1_pixel};

  always_comb begin
    spread = '0;
    for (int j = 0; j < MAX_ELEMENT; j++) begin
      spread[j*GRID] = col_bits[j];
    end
    window_next = ((stage.window << 1) & ~COL0_BITS) | spread;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      stage.valid  <= 1'b0;
      stage.window <= '0;
    end else if (advance) begin
      s1_valid    <= accept;
      stage.valid <= s1_valid;
      if (s1_valid) begin
        stage.window <= window_next;
        stage.x      <= s1_x;
        stage.y      <= s1_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (accept) begin
        s1_pixel    <= pixel;
        s1_x        <= x;
        s1_y        <= y;
        s1_fwd      <= s1_valid && (s1_x == x);
        s1_fwd_data <= col_bits[LINE_BITS-1:0];
      end
    end
  end

endmodule

// File: hw/rtl/bde_result.sv
// ----------------------------------------------------------------------------
// Result stage
// Reduces the window against the structuring element and holds the result.
// ----------------------------------------------------------------------------
module bde_result import bde_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  cfg_t             cfg,
  input  win_stage_t       stage,
  output logic             out_valid,
  output logic             out_pixel,
  output logic [COL_W-1:0] out_column,
  output logic [ROW_W-1:0] out_row
);

  logic [WIN_BITS-1:0] inside_img;
  logic                dil_hit;
  logic                ero_hit;
  logic                fits;
  logic [SIZE_W-1:0]   x_inc;
  logic [SIZE_W-1:0]   y_inc;
  logic                emit;
  logic                result;
  logic [COL_W-1:0]    col;
  logic [ROW_W-1:0]    row;

  // Window positions left of column 0 or above row 0 count as background.
  always_comb begin
    for (int j = 0; j < GRID; j++) begin
      for (int i = 0; i < GRID; i++) begin
        inside_img[j*GRID+i] = (stage.x >= COL_W'(i)) && (stage.y >= ROW_W'(j));
      end
    end
  end

  assign dil_hit = |(cfg.dil_mask & stage.window & inside_img);
  assign ero_hit = &(~cfg.ero_mask | stage.window);

  assign x_inc = SIZE_W'(stage.x) + SIZE_W'(1);
  assign y_inc = SIZE_W'(stage.y) + SIZE_W'(1);
  assign fits  = (x_inc >= SIZE_W'(cfg.ew)) && (y_inc >= SIZE_W'(cfg.eh));

  always_comb begin
    if (cfg.erode == MODE_ERODE) begin
      emit   = fits;
      result = ero_hit;
      col    = stage.x + COL_W'(1) - COL_W'(cfg.ew);
      row    = stage.y + ROW_W'(1) - ROW_W'(cfg.eh);
    end else begin
      emit   = 1'b1;
      result = dil_hit;
      col    = stage.x;
      row    = stage.y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage.valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage.valid) begin
      out_pixel  <= result;
      out_column <= col;
      out_row    <= row;
    end
  end

endmodule

// File: hw/rtl/binary_dilation_erosion_unit.sv
// ----------------------------------------------------------------------------
// Binary dilation / erosion unit
// Streams binary pixels in raster order and returns the dilated or eroded
// image, with the structuring element anchored at its top-left corner.
// ----------------------------------------------------------------------------
// Usage:
//   pixels  - input channel, one pixel per transaction; frame_start puts the
//             pixel at column 0, row 0.
//   results - output channel, one pixel with its column and row.
//   cfg     - register writes (mode, element mask and size, image size);
//             write only while no pixel is in flight.
// A pixel passes the s1 stage, the window stage and the result register.
// Throughput: one pixel per cycle while the receiver does not stall, limited by
//   the single read and single write port of the line store, both used per pixel.
// Dilation returns one result per pixel; erosion returns none while the
//   element does not yet fit above and left of the newest pixel.
// Reset clears the position counters, the window and all valid flags;
//   the line store is not cleared, it fills during the first rows.
// When the receiver stalls, the whole pipeline holds and pixels.ready drops
//   in the same cycle; nothing is lost and the held result stays steady.
// ----------------------------------------------------------------------------
`include "binary_dilation_erosion_unit_defines.svh"

module binary_dilation_erosion_unit import bde_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  bde_pixel_if.sink   pixels,
  bde_result_if.source results,
  bde_cfg_if.sink     cfg
);

  cfg_t       cfg_eff;
  win_stage_t stage;
  logic       advance;

  // Hold every stage while a finished result waits.
  assign advance      = !results.valid || results.ready;
  assign pixels.ready = advance;

  bde_config u_config (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_ready (cfg.ready),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_eff)
  );

  bde_line_window u_line_window (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .in_valid    (pixels.valid),
    .pixel       (pixels.pixel),
    .frame_start (pixels.frame_start),
    .cfg         (cfg_eff),
    .stage       (stage)
  );

  bde_result u_result (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .cfg        (cfg_eff),
    .stage      (stage),
    .out_valid  (results.valid),
    .out_pixel  (results.out_pixel),
    .out_column (results.out_column),
    .out_row    (results.out_row)
  );

  `BDE_ASSERT_IMPLY(a_stall_blocks_input, clk, rst, results.valid && !results.ready, !pixels.ready)
  `BDE_ASSERT_NEXT(a_bubble_gives_no_result, clk, rst, advance && !stage.valid, !results.valid)
  `BDE_ASSERT_RESET(a_reset_clears_output, clk, rst, !results.valid)

endmodule

// File: tb/tb_binary_dilation_erosion_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary dilation / erosion unit testbench
// Streams binary frames through the unit under several element and image
// settings and idling patterns, predicts each output pixel and its position
// in a scoreboard, and compares every result transaction in order.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic                      pix;
  logic [bde_pkg::COL_W-1:0] column;
  logic [bde_pkg::ROW_W-1:0] row;
} morph_pixel_t;

class morph_scoreboard;
  logic [bde_pkg::LINE_BITS-1:0] line_mem [bde_pkg::MAX_WIDTH];
  logic [bde_pkg::WIN_BITS-1:0]  win;
  int unsigned                   col_cnt;
  int unsigned                   row_cnt;

  logic                          erode;
  logic [63:0]                   se_mask;
  logic [bde_pkg::ELEM_W-1:0]    se_w;
  logic [bde_pkg::ELEM_W-1:0]    se_h;
  logic [bde_pkg::SIZE_W-1:0]    img_w;
  logic [bde_pkg::SIZE_W-1:0]    img_h;

  morph_pixel_t                  expected_pixels[$];
  int unsigned                   failures;

  function new();
    foreach (line_mem[k]) line_mem[k] = '0;
    win      = '0;
    col_cnt  = 0;
    row_cnt  = 0;
    erode    = bde_pkg::MODE_ERODE == 1'b0;
    se_mask  = 64'd1;
    se_w     = bde_pkg::ELEM_W'(1);
    se_h     = bde_pkg::ELEM_W'(1);
    img_w    = bde_pkg::SIZE_W'(1024);
    img_h    = bde_pkg::SIZE_W'(1024);
    failures = 0;
  endfunction

  static function int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function void write_reg(logic [bde_pkg::INDEX_W-1:0] idx, logic [63:0] data);
    case (idx)
      bde_pkg::REG_MODE:           erode   = (data[0] == bde_pkg::MODE_ERODE);
      bde_pkg::REG_ELEMENT_MASK:   se_mask = data;
      bde_pkg::REG_ELEMENT_WIDTH:  se_w    = data[bde_pkg::ELEM_W-1:0];
      bde_pkg::REG_ELEMENT_HEIGHT: se_h    = data[bde_pkg::ELEM_W-1:0];
      bde_pkg::REG_IMAGE_WIDTH:    img_w   = data[bde_pkg::SIZE_W-1:0];
      bde_pkg::REG_IMAGE_HEIGHT:   img_h   = data[bde_pkg::SIZE_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the window by one pixel and queue the output it produces, if any.
  function void note_pixel(logic pix, logic fs);
    int unsigned                  iw, ih, ew, eh, x, y;
    logic [bde_pkg::MAX_ELEMENT-1:0] column;
    logic [bde_pkg::WIN_BITS-1:0] spread;
    logic                         hit;
    iw = clamp_size(img_w, bde_pkg::MAX_WIDTH);
    ih = clamp_size(img_h, bde_pkg::MAX_ROWS);
    ew = clamp_size(se_w, bde_pkg::MAX_ELEMENT);
    eh = clamp_size(se_h, bde_pkg::MAX_ELEMENT);
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    if (col_cnt >= iw) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= ih) row_cnt = 0;
    x = col_cnt;
    y = row_cnt;

    column = {line_mem[x], pix};
    line_mem[x] = column[bde_pkg::LINE_BITS-1:0];
    spread = '0;
    for (int j = 0; j < bde_pkg::MAX_ELEMENT; j++) spread[j*bde_pkg::GRID] = column[j];
    win = ((win << 1) & ~bde_pkg::COL0_BITS) | spread;

    if (!erode) begin
      hit = 1'b0;
      for (int unsigned j = 0; j < eh; j++)
        for (int unsigned i = 0; i < ew; i++)
          if (se_mask[j*bde_pkg::GRID+i] && i <= x && j <= y && win[j*bde_pkg::GRID+i])
            hit = 1'b1;
      expected_pixels.push_back('{hit, bde_pkg::COL_W'(x), bde_pkg::ROW_W'(y)});
    end else if (x + 1 >= ew && y + 1 >= eh) begin
      // Anchor is the top-left corner: element (j,i) sits (eh-1-j, ew-1-i) back.
      hit = 1'b1;
      for (int unsigned j = 0; j < eh; j++)
        for (int unsigned i = 0; i < ew; i++)
          if (se_mask[j*bde_pkg::GRID+i] &&
              !win[(eh-1-j)*bde_pkg::GRID + (ew-1-i)])
            hit = 1'b0;
      expected_pixels.push_back('{hit, bde_pkg::COL_W'(x + 1 - ew),
                                  bde_pkg::ROW_W'(y + 1 - eh)});
    end

    if (x + 1 >= iw) begin
      col_cnt = 0;
      row_cnt = (y + 1 >= ih) ? 0 : y + 1;
    end else begin
      col_cnt = x + 1;
      row_cnt = y;
    end
  endfunction

  function void check_result(logic pix, logic [bde_pkg::COL_W-1:0] c,
                             logic [bde_pkg::ROW_W-1:0] r);
    morph_pixel_t want;
    if (expected_pixels.size() == 0) begin
      if (failures < 10)
        $display("unexpected result: pixel %0d at column %0d row %0d", pix, c, r);
      failures++;
    end else begin
      want = expected_pixels.pop_front();
      if (want.pix !== pix || want.column !== c || want.row !== r) begin
        if (failures < 10)
          $display("mismatch: expected pixel %0d at column %0d row %0d, got %0d at %0d %0d",
                   want.pix, want.column, want.row, pix, c, r);
        failures++;
      end
    end
  endfunction
endclass

module tb_binary_dilation_erosion_unit;
  import bde_pkg::*;

  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int SUBPHASE_PIXELS = 30;

  localparam logic [INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  logic clk;
  logic rst;

  bde_pixel_if  pixels();
  bde_result_if results();
  bde_cfg_if    cfg();

  binary_dilation_erosion_unit dut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pixels),
    .results (results),
    .cfg     (cfg)
  );

  morph_scoreboard sb;
  int unsigned     sender_gap_pct     = 0;
  int unsigned     receiver_stall_pct = 0;
  bit              hold_start         = 0;
  bit              hold_off           = 0;
  int unsigned     quiet_cycles       = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    results.ready = 1'b0;
    forever begin
      @(negedge clk);
      results.ready = !hold_off && ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Long receiver hold-off so the pipeline fills and back-pressures the input.
  initial begin
    wait (hold_start);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg.valid && cfg.ready) sb.write_reg(cfg.index, cfg.data);
      if (pixels.valid && pixels.ready) sb.note_pixel(pixels.pixel, pixels.frame_start);
      if (results.valid && results.ready)
        sb.check_result(results.out_pixel, results.out_column, results.out_row);
    end
  end

  always @(posedge clk) begin
    if (rst || (pixels.valid && pixels.ready) || (results.valid && results.ready) ||
        (cfg.valid && cfg.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_pixel(input logic pix, input logic fs);
    @(negedge clk);
    while ($urandom_range(99) < sender_gap_pct) begin
      pixels.valid = 1'b0;
      @(negedge clk);
    end
    pixels.valid       = 1'b1;
    pixels.pixel       = pix;
    pixels.frame_start = fs;
    do @(posedge clk); while (!pixels.ready);
  endtask

  task automatic set_register(input logic [INDEX_W-1:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = data;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  // Drop valid, drain every expected result, then let erosion stragglers settle.
  task automatic wait_idle();
    @(negedge clk);
    pixels.valid = 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [ELEM_W-1:0] pick_element_size();
    case ($urandom_range(19))
      0:       return '0;
      1:       return ELEM_W'($urandom_range(15, 9));
      default: return ELEM_W'($urandom_range(8, 1));
    endcase
  endfunction

  function automatic logic [63:0] pick_mask();
    case ($urandom_range(3))
      0:       return '1;
      1:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      2:       return {$urandom, $urandom};
      default: return 64'd1 << $urandom_range(63);
    endcase
  endfunction

  task automatic set_element();
    logic [63:0] data;
    set_register(REG_ELEMENT_MASK, pick_mask());
    data = {$urandom, $urandom};
    data[ELEM_W-1:0] = pick_element_size();
    set_register(REG_ELEMENT_WIDTH, data);
    data = {$urandom, $urandom};
    data[ELEM_W-1:0] = pick_element_size();
    set_register(REG_ELEMENT_HEIGHT, data);
  endtask

  task automatic configure_random(output int unsigned iw, output int unsigned ih);
    logic [63:0]       data;
    logic [SIZE_W-1:0] w, h;
    data = {$urandom, $urandom};
    data[0] = 1'($urandom_range(1));
    set_register(REG_MODE, data);
    set_element();
    w = ($urandom_range(15) == 0) ? '0 : SIZE_W'($urandom_range(24, 1));
    h = ($urandom_range(15) == 0) ? '0 : SIZE_W'($urandom_range(12, 1));
    data = {$urandom, $urandom};
    data[SIZE_W-1:0] = w;
    set_register(REG_IMAGE_WIDTH, data);
    data = {$urandom, $urandom};
    data[SIZE_W-1:0] = h;
    set_register(REG_IMAGE_HEIGHT, data);
    iw = (w == 0) ? 1 : w;
    ih = (h == 0) ? 1 : h;
  endtask

  // Mostly whole frames with random content; some cut short, a few stray frame starts.
  task automatic stream_frames(input int budget, input int unsigned iw, input int unsigned ih);
    int          sent;
    int unsigned frame_len;
    int unsigned density;
    logic        fs;
    sent = 0;
    while (sent < budget) begin
      frame_len = iw * ih;
      if ($urandom_range(9) == 0) frame_len = $urandom_range(frame_len, 1);
      case ($urandom_range(2))
        0:       density = 8;
        1:       density = 50;
        default: density = 92;
      endcase
      for (int unsigned k = 0; k < frame_len && sent < budget; k++) begin
        fs = (sent == 0) || (k == 0 && $urandom_range(9) != 0) || ($urandom_range(199) == 0);
        send_pixel($urandom_range(99) < density, fs);
        sent++;
      end
    end
  endtask

  // Dilation over a very wide or very tall image to reach the last column and row.
  task automatic run_long_line(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                               input int count);
    set_register(REG_MODE, 64'(MODE_DILATE));
    set_element();
    set_register(REG_IMAGE_WIDTH, 64'(w));
    set_register(REG_IMAGE_HEIGHT, 64'(h));
    for (int k = 0; k < count; k++) send_pixel(1'($urandom_range(1)), k == 0);
    wait_idle();
  endtask

  initial begin
    int unsigned iw, ih;
    rst                = 1'b1;
    pixels.valid       = 1'b0;
    pixels.pixel       = 1'b0;
    pixels.frame_start = 1'b0;
    cfg.valid          = 1'b0;
    cfg.index          = REG_MODE;
    cfg.data           = '0;
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: identity pass over a 1024 by 1024 image
    send_pixel(1'b1, 1'b1);
    send_pixel(1'b0, 1'b0);
    send_pixel(1'b1, 1'b0);
    wait_idle();

    // Dilation with a full element clamped to 8 by 8; border pixels fall outside
    set_register(REG_SPARE_LO, {$urandom, $urandom});
    set_register(REG_SPARE_HI, {$urandom, $urandom});
    set_register(REG_ELEMENT_MASK, '1);
    set_register(REG_ELEMENT_WIDTH, 64'd15);
    set_register(REG_ELEMENT_HEIGHT, 64'd9);
    set_register(REG_IMAGE_WIDTH, 64'd4);
    set_register(REG_IMAGE_HEIGHT, 64'd3);
    send_pixel(1'b1, 1'b1);
    send_pixel(1'b0, 1'b0);
    send_pixel(1'b0, 1'b0);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b0, 1'b0);
    send_pixel(1'b1, 1'b1);
    send_pixel(1'b0, 1'b0);
    wait_idle();

    // Erosion with an empty element; run past the end of frame so it wraps
    set_register(REG_MODE, 64'(MODE_ERODE));
    set_register(REG_ELEMENT_MASK, '0);
    set_register(REG_ELEMENT_WIDTH, 64'd2);
    set_register(REG_ELEMENT_HEIGHT, 64'd2);
    set_register(REG_IMAGE_WIDTH, 64'd3);
    set_register(REG_IMAGE_HEIGHT, 64'd2);
    send_pixel(1'b1, 1'b1);
    send_pixel(1'b0, 1'b0);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b0, 1'b0);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b1, 1'b0);
    wait_idle();

    // Zero sizes act as one; the position left past the new size wraps
    set_register(REG_ELEMENT_MASK, '1);
    set_register(REG_ELEMENT_WIDTH, 64'd0);
    set_register(REG_ELEMENT_HEIGHT, 64'd0);
    set_register(REG_IMAGE_WIDTH, 64'd0);
    set_register(REG_IMAGE_HEIGHT, 64'd0);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b0, 1'b0);
    send_pixel(1'b1, 1'b0);
    wait_idle();

    run_long_line(SIZE_W'(2047), SIZE_W'(1), 1030);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin sender_gap_pct = 0;  receiver_stall_pct = 0;  end
        1:       begin sender_gap_pct = 53; receiver_stall_pct = 0;  end
        2:       begin sender_gap_pct = 0;  receiver_stall_pct = 53; end
        default: begin sender_gap_pct = 18; receiver_stall_pct = 18; end
      endcase
      for (int s = 0; s < 3; s++) begin
        configure_random(iw, ih);
        if (phase == 0 && s == 1) hold_start = 1'b1;
        stream_frames(SUBPHASE_PIXELS, iw, ih);
        wait_idle();
      end
    end

    if (sb.failures == 0 && sb.expected_pixels.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
